// File: hdl/umrm_pkg.sv
`timescale 1ns / 1ps
package umrm_pkg;
    localparam int DEPTH     = 16;
    localparam int ADDR_BITS = 48;
    localparam int IDX_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int CFG_BITS  = 48;
    localparam logic [ADDR_BITS-1:0] LOW_FLOOR = ADDR_BITS'(64'h1000);

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_SCAN  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEARED   = 3'd0,
        ST_MERGED    = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_DROP_EMPTY = 3'd3,
        ST_DROP_FULL = 3'd4,
        ST_PIECE     = 3'd5,
        ST_SCAN_END  = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        REG_LIMIT  = 3'd0,
        REG_KBASE  = 3'd1,
        REG_KLEN   = 3'd2,
        REG_BBASE  = 3'd3,
        REG_BUSED  = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MSEARCH,
        S_SHIFT,
        S_SCAN,
        S_REPORT
    } state_t;

    // Control from sequencer to the cell row
    typedef struct packed {
        logic                 clear;
        logic                 rotate;     // every cell hands its entry to the next lower one, cell 0 to the top one
        logic                 write_en;   // write head cell 0 (load wins over rotate there)
        logic [ADDR_BITS-1:0] wr_first;
        logic [ADDR_BITS-1:0] wr_last;
        logic                 wr_last_only;
    } row_ctrl_t;
endpackage

// File: hdl/umrm_cell.sv
`timescale 1ns / 1ps
// One table entry; takes its neighbour's content on rotate, load taking priority.
module umrm_cell (
    input  logic                            clk,
    input  logic                            rotate,
    input  logic                            load,
    input  logic                            load_last_only,
    input  logic [umrm_pkg::ADDR_BITS-1:0]  load_first,
    input  logic [umrm_pkg::ADDR_BITS-1:0]  load_last,
    input  logic [umrm_pkg::ADDR_BITS-1:0]  nb_first,
    input  logic [umrm_pkg::ADDR_BITS-1:0]  nb_last,
    output logic [umrm_pkg::ADDR_BITS-1:0]  first,
    output logic [umrm_pkg::ADDR_BITS-1:0]  last
);
    logic [umrm_pkg::ADDR_BITS-1:0] first_reg, last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            last_reg <= load_last;
            if (!load_last_only)
                first_reg <= load_first;
        end
        else if (rotate)
        begin
            first_reg <= nb_first;
            last_reg  <= nb_last;
        end
    end

    assign first = first_reg;
    assign last  = last_reg;
endmodule

// File: hdl/umrm_row.sv
`timescale 1ns / 1ps
// Ring of cells. Cell 0 is the head that the sequencer sees; a rotate moves
// every entry one place toward the head, the head going to the tail.
module umrm_row (
    input  logic                            clk,
    input  umrm_pkg::row_ctrl_t             ctrl,
    output logic [umrm_pkg::ADDR_BITS-1:0]  head_first,
    output logic [umrm_pkg::ADDR_BITS-1:0]  head_last
);
    logic [umrm_pkg::ADDR_BITS-1:0] f [umrm_pkg::DEPTH];
    logic [umrm_pkg::ADDR_BITS-1:0] l [umrm_pkg::DEPTH];

    for (genvar g = 0; g < umrm_pkg::DEPTH; g++)
    begin : g_cell
        localparam int NB = (g + 1) % umrm_pkg::DEPTH;
        umrm_cell u_cell (
            .clk            (clk),
            .rotate         (ctrl.rotate),
            .load           (ctrl.write_en && (g == 0)),
            .load_last_only (ctrl.wr_last_only),
            .load_first     (ctrl.wr_first),
            .load_last      (ctrl.wr_last),
            .nb_first       (f[NB]),
            .nb_last        (l[NB]),
            .first          (f[g]),
            .last           (l[g])
        );
    end

    assign head_first = f[0];
    assign head_last  = l[0];
endmodule

// File: hdl/usable_memory_region_map_unit.sv
`timescale 1ns / 1ps
// Usable memory region map. The table lives in a ring of DEPTH cells that
// rotates one place a cycle past a single compare unit at its head, except
// while the head is written or examined again after a cut. Clear and an
// empty range go straight to the report. Add first makes one full turn to
// look for an entry to extend, and a full-table drop is reported after it. A
// merge then makes a second turn that rewrites that entry. An insert makes
// a second turn that lets the new range fall into its place, holding the
// ring for each entry moved up. Scan makes one turn and examines the head
// again after each cut. busy is high throughout;
// results appear on the strobe for one cycle each and cannot be held off
// by the receiver.
module usable_memory_region_map_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [47:0] range_first,
    input  logic [47:0] range_final,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    output logic        result_valid,
    output logic [2:0]  status,
    output logic [47:0] piece_start,
    output logic [48:0] piece_size,
    output logic        last
);
    localparam int AB = umrm_pkg::ADDR_BITS;
    localparam int IB = umrm_pkg::IDX_BITS;
    localparam int CB = umrm_pkg::CNT_BITS;

    // configuration
    logic [4:0]    limit_reg;
    logic [AB-1:0] kbase_reg, klen_reg, bbase_reg, bused_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 5'd16;
            kbase_reg <= '0;
            klen_reg  <= '0;
            bbase_reg <= '0;
            bused_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                umrm_pkg::REG_LIMIT: limit_reg <= cfg_data[4:0];
                umrm_pkg::REG_KBASE: kbase_reg <= cfg_data;
                umrm_pkg::REG_KLEN:  klen_reg  <= cfg_data;
                umrm_pkg::REG_BBASE: bbase_reg <= cfg_data;
                umrm_pkg::REG_BUSED: bused_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer state
    umrm_pkg::state_t   state_reg, state_next;
    logic [CB-1:0]      count_reg, count_next;
    logic [IB:0]        step_reg, step_next;     // ring steps done this turn
    logic [AB-1:0]      first_reg, first_next;
    logic [AB-1:0]      final_reg, final_next;
    logic [AB:0]        mark_reg, mark_next;     // watermark, or entry index in add
    logic               found_reg, found_next;   // merge candidate found / insert placed
    logic               cut_reg, cut_next;       // insert swap just written at the head, rotate now
    logic [2:0]         st_reg, st_next;
    logic               rv_reg, rv_next;
    logic [2:0]         ost_reg, ost_next;
    logic [AB-1:0]      ops_reg, ops_next;
    logic [AB:0]        osz_reg, osz_next;
    logic               olast_reg, olast_next;

    umrm_pkg::row_ctrl_t ctrl;
    logic [AB-1:0]       hf, hl;

    umrm_row u_row (
        .clk        (clk),
        .ctrl       (ctrl),
        .head_first (hf),
        .head_last  (hl)
    );

    // scan arithmetic on the head entry; watermark kept one bit wider
    logic [AB-1:0] s_e1, s_e2;
    logic [AB:0]   s_s, s_m1, s_m2, hl_inc;
    logic          k_cut, b_cut;
    logic [CB-1:0] lim_eff;
    logic          in_table;

    always_comb
    begin
        hl_inc = {1'b0, hl} + 1'b1;
        s_s   = (mark_reg > {1'b0, hf}) ? mark_reg : {1'b0, hf};
        k_cut = (klen_reg != '0) && (kbase_reg < hl) && ({1'b0, kbase_reg} >= s_s);
        s_e1  = k_cut ? kbase_reg - 1'b1 : hl;
        s_m1  = k_cut ? {1'b0, kbase_reg} + {1'b0, klen_reg} : hl_inc;
        b_cut = (bused_reg != '0) && (bbase_reg < s_e1) && ({1'b0, bbase_reg} >= s_s);
        s_e2  = b_cut ? bbase_reg - 1'b1 : s_e1;
        s_m2  = b_cut ? {1'b0, bbase_reg} + {1'b0, bused_reg} : s_m1;
        lim_eff = (limit_reg > 5'(umrm_pkg::DEPTH)) ? CB'(umrm_pkg::DEPTH) : CB'(limit_reg);
        in_table = ({1'b0, step_reg} < (IB+2)'(count_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= umrm_pkg::S_IDLE;
            count_reg <= '0;
            rv_reg    <= 1'b0;
            step_reg  <= '0;
            found_reg <= 1'b0;
            cut_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rv_reg    <= rv_next;
            step_reg  <= step_next;
            found_reg <= found_next;
            cut_reg   <= cut_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        final_reg <= final_next;
        mark_reg  <= mark_next;
        st_reg    <= st_next;
        ost_reg   <= ost_next;
        ops_reg   <= ops_next;
        osz_reg   <= osz_next;
        olast_reg <= olast_next;
    end

    // Ring position: the head holds entry (step mod DEPTH). A full turn
    // (DEPTH rotates) returns entry 0 to the head.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        step_next  = step_reg;
        first_next = first_reg;
        final_next = final_reg;
        mark_next  = mark_reg;
        found_next = found_reg;
        cut_next   = cut_reg;
        st_next    = st_reg;
        rv_next    = 1'b0;
        ost_next   = ost_reg;
        ops_next   = ops_reg;
        osz_next   = osz_reg;
        olast_next = olast_reg;
        ctrl       = '0;
        ctrl.wr_first = first_reg;
        ctrl.wr_last  = final_reg;

        case (state_reg)
            umrm_pkg::S_IDLE:
            begin
                if (start && !busy)
                begin
                    first_next = (range_first == '0) ? umrm_pkg::LOW_FLOOR : range_first;
                    final_next = range_final;
                    step_next  = '0;
                    found_next = 1'b0;
                    cut_next   = 1'b0;
                    mark_next  = '0;
                    case (op)
                        umrm_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            st_next    = umrm_pkg::ST_CLEARED;
                            state_next = umrm_pkg::S_REPORT;
                        end
                        umrm_pkg::OP_ADD:
                        begin
                            if (range_final < ((range_first == '0) ? umrm_pkg::LOW_FLOOR
                                                                  : range_first))
                            begin
                                st_next    = umrm_pkg::ST_DROP_EMPTY;
                                state_next = umrm_pkg::S_REPORT;
                            end
                            else
                                state_next = umrm_pkg::S_MSEARCH;
                        end
                        umrm_pkg::OP_SCAN:
                            state_next = umrm_pkg::S_SCAN;
                        default: ;
                    endcase
                end
            end

            // Merge search: model goes top down and stops at first entry with
            // last+1 < first. Going upward, a break at entry i clears earlier
            // candidates and marks i+1 as the insert place; an entry with
            // last+1 == first marks itself as the one to extend.
            umrm_pkg::S_MSEARCH:
            begin
                if (step_reg == (IB+1)'(umrm_pkg::DEPTH))
                begin
                    step_next = '0;
                    if (found_reg)
                    begin
                        st_next    = umrm_pkg::ST_MERGED;
                        state_next = umrm_pkg::S_REPORT;
                    end
                    else if (count_reg >= lim_eff)
                    begin
                        st_next    = umrm_pkg::ST_DROP_FULL;
                        state_next = umrm_pkg::S_REPORT;
                    end
                    else
                    begin
                        st_next    = umrm_pkg::ST_INSERTED;
                        state_next = umrm_pkg::S_SHIFT;
                    end
                end
                else
                begin
                    ctrl.rotate = 1'b1;
                    step_next   = step_reg + 1'b1;
                    if (in_table)
                    begin
                        if (hl_inc < {1'b0, first_reg})
                        begin
                            found_next = 1'b0;
                            mark_next  = (AB+1)'(step_reg) + 1'b1;
                        end
                        else if (hl_inc == {1'b0, first_reg})
                        begin
                            found_next = 1'b1;
                            mark_next  = (AB+1)'(step_reg);
                        end
                    end
                end
            end

            default: ;
        endcase

        // second pass of a merge: rewrite the chosen entry in place
        if (state_reg == umrm_pkg::S_MSEARCH && step_reg == (IB+1)'(umrm_pkg::DEPTH)
            && found_reg)
        begin
            state_next = umrm_pkg::S_SHIFT;
            st_next    = umrm_pkg::ST_MERGED;
        end

        case (state_reg)
            // Insert/merge turn: walk the ring; at the target place either
            // overwrite the last address (merge) or hold the new range and
            // carry displaced entries upward one at a time.
            umrm_pkg::S_SHIFT:
            begin
                if (step_reg == (IB+1)'(umrm_pkg::DEPTH))
                begin
                    step_next = '0;
                    if (st_reg == umrm_pkg::ST_INSERTED)
                    begin
                        count_next = count_reg + 1'b1;
                        st_next    = umrm_pkg::ST_INSERTED;
                    end
                    state_next = umrm_pkg::S_REPORT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                    if (st_reg == umrm_pkg::ST_MERGED)
                    begin
                        if ((AB+1)'(step_reg) == mark_reg)
                        begin
                            ctrl.write_en     = 1'b1;
                            ctrl.wr_last_only = 1'b1;
                            ctrl.wr_last      = final_reg;
                        end
                        else
                            ctrl.rotate = 1'b1;
                        if ((AB+1)'(step_reg) == mark_reg)
                            step_next = step_reg;
                        if ((AB+1)'(step_reg) == mark_reg)
                            st_next = umrm_pkg::ST_SCAN_END; // marker: done write
                    end
                    else if (st_reg == umrm_pkg::ST_SCAN_END)
                    begin
                        ctrl.rotate = 1'b1;
                        st_next     = umrm_pkg::ST_SCAN_END;
                    end
                    else
                    begin
                        // insert: from the marked place up to count, swap the
                        // carried range with the head (entries at/above count are free)
                        ctrl.rotate = 1'b1;
                        if (found_reg || ((AB+1)'(step_reg) == mark_reg))
                        begin
                            if ({1'b0, step_reg} <= (IB+2)'(count_reg))
                            begin
                                ctrl.rotate   = 1'b0;
                                ctrl.write_en = 1'b1;
                                ctrl.wr_first = first_reg;
                                ctrl.wr_last  = final_reg;
                                first_next    = hf;
                                final_next    = hl;
                                found_next    = 1'b1;
                                step_next     = step_reg;
                                cut_next      = 1'b1;
                            end
                        end
                        if (cut_reg)
                        begin
                            ctrl.rotate   = 1'b1;
                            ctrl.write_en = 1'b0;
                            step_next     = step_reg + 1'b1;
                            cut_next      = 1'b0;
                            first_next    = first_reg;
                            final_next    = final_reg;
                        end
                    end
                end
                if (state_next == umrm_pkg::S_REPORT && st_reg == umrm_pkg::ST_SCAN_END)
                    st_next = umrm_pkg::ST_MERGED;
            end

            // Scan: the head entry is examined; after a cut the same entry
            // is examined again with the new watermark before rotating.
            umrm_pkg::S_SCAN:
            begin
                if (step_reg == (IB+1)'(umrm_pkg::DEPTH) || !in_table)
                begin
                    if (step_reg == (IB+1)'(umrm_pkg::DEPTH))
                    begin
                        rv_next    = 1'b1;
                        ost_next   = umrm_pkg::ST_SCAN_END;
                        ops_next   = '0;
                        osz_next   = '0;
                        olast_next = 1'b1;
                        state_next = umrm_pkg::S_IDLE;
                    end
                    else
                    begin
                        ctrl.rotate = 1'b1;
                        step_next   = step_reg + 1'b1;
                    end
                end
                else if (s_s > {1'b0, hl})
                begin
                    ctrl.rotate = 1'b1;
                    step_next   = step_reg + 1'b1;
                end
                else
                begin
                    mark_next = s_m2;
                    if (!(k_cut || b_cut))
                    begin
                        ctrl.rotate = 1'b1;
                        step_next   = step_reg + 1'b1;
                    end
                    if (s_s <= {1'b0, s_e2})
                    begin
                        rv_next    = 1'b1;
                        ost_next   = umrm_pkg::ST_PIECE;
                        ops_next   = s_s[AB-1:0];
                        osz_next   = {1'b0, s_e2} - s_s + 1'b1;
                        olast_next = 1'b0;
                    end
                end
            end

            umrm_pkg::S_REPORT:
            begin
                rv_next    = 1'b1;
                ost_next   = st_reg;
                ops_next   = '0;
                osz_next   = '0;
                olast_next = 1'b1;
                state_next = umrm_pkg::S_IDLE;
            end

            default: ;
        endcase
    end

    assign busy         = (state_reg != umrm_pkg::S_IDLE) || rv_reg;
    assign result_valid = rv_reg;
    assign status       = ost_reg;
    assign piece_start  = ops_reg;
    assign piece_size   = osz_reg;
    assign last         = olast_reg;
endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 3 * umrm_pkg::DEPTH + 40;
    localparam int PHASES      = 14;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  op;
    logic [47:0] range_first;
    logic [47:0] range_final;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;
    logic        result_valid;
    logic [2:0]  status;
    logic [47:0] piece_start;
    logic [48:0] piece_size;
    logic        last;

    typedef struct {
        logic [2:0]  status;
        logic [47:0] start;
        logic [48:0] size;
        logic        last;
    } region_result_t;

    typedef struct {
        umrm_pkg::op_t     op;
        logic [47:0]       first;
        logic [47:0]       final_addr;
        bit                typed;
        umrm_pkg::status_t want;
    } stim_row_t;

    // Expected results still to arrive, oldest first
    region_result_t pending_results[$];

    // Own copy of the region table and registers
    logic [63:0] tbl_first[umrm_pkg::DEPTH];
    logic [63:0] tbl_last[umrm_pkg::DEPTH];
    int          tbl_count;
    logic [63:0] lim_reg, kbase_reg, klen_reg, bbase_reg, bused_reg;

    int                errors, items_sent, results_seen, pieces_seen, full_drops, cycles;
    umrm_pkg::status_t last_predicted;

    usable_memory_region_map_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .range_first(range_first), .range_final(range_final),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .result_valid(result_valid), .status(status), .piece_start(piece_start),
        .piece_size(piece_size), .last(last)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    task automatic push_result(input umrm_pkg::status_t st, input logic [63:0] s,
                               input logic [63:0] sz, input logic lst);
        region_result_t r;
        r.status = st;
        r.start  = s[47:0];
        r.size   = sz[48:0];
        r.last   = lst;
        pending_results.push_back(r);
        last_predicted = st;
    endtask

    // Add: drop if empty, merge onto an entry ending one below, else sorted insert if not full
    function automatic umrm_pkg::status_t add_region(input logic [63:0] first,
                                                     input logic [63:0] fin);
        int          i;
        int          cap;
        logic [63:0] nx;
        if (first == 0)
            first = 64'(umrm_pkg::LOW_FLOOR);
        if (fin < first)
            return umrm_pkg::ST_DROP_EMPTY;
        for (i = tbl_count - 1; i >= 0; i--)
        begin
            nx = tbl_last[i] + 1;
            if (nx < first)
                break;
            if (nx == first)
            begin
                tbl_last[i] = fin;
                return umrm_pkg::ST_MERGED;
            end
        end
        cap = (lim_reg > umrm_pkg::DEPTH) ? umrm_pkg::DEPTH : int'(lim_reg);
        if (tbl_count >= cap)
            return umrm_pkg::ST_DROP_FULL;
        for (i = tbl_count - 1; i >= 0; i--)
        begin
            if (tbl_last[i] + 1 < first)
                break;
            tbl_first[i + 1] = tbl_first[i];
            tbl_last[i + 1]  = tbl_last[i];
        end
        tbl_first[i + 1] = first;
        tbl_last[i + 1]  = fin;
        tbl_count++;
        return umrm_pkg::ST_INSERTED;
    endfunction

    // Walk the table with a watermark, cutting out kernel and boot memory
    task automatic scan_free_pieces();
        logic [63:0] mark, s, e;
        int          i, n;
        mark = 0;
        i = 0;
        n = 0;
        while (i < tbl_count && i < umrm_pkg::DEPTH && n < 3 * umrm_pkg::DEPTH)
        begin
            s = tbl_first[i];
            e = tbl_last[i];
            if (mark > s)
                s = mark;
            if (s > e)
            begin
                i++;
                continue;
            end
            mark = e + 1;
            if (klen_reg != 0 && kbase_reg < e && kbase_reg >= s)
            begin
                e = kbase_reg - 1;
                mark = kbase_reg + klen_reg;
            end
            if (bused_reg != 0 && bbase_reg < e && bbase_reg >= s)
            begin
                e = bbase_reg - 1;
                mark = bbase_reg + bused_reg;
            end
            if (s > e)
                continue;
            push_result(umrm_pkg::ST_PIECE, s, e - s + 1, 1'b0);
            n++;
        end
        push_result(umrm_pkg::ST_SCAN_END, 0, 0, 1'b1);
    endtask

    task automatic predict_item(input umrm_pkg::op_t o, input logic [47:0] f,
                                input logic [47:0] l);
        case (o)
            umrm_pkg::OP_CLEAR:
            begin
                tbl_count = 0;
                push_result(umrm_pkg::ST_CLEARED, 0, 0, 1'b1);
            end
            umrm_pkg::OP_ADD:
                push_result(add_region(64'(f), 64'(l)), 0, 0, 1'b1);
            umrm_pkg::OP_SCAN:
                scan_free_pieces();
            default: ;
        endcase
    endtask

    // Hold start until busy is low at an edge, then predict
    task automatic issue(input umrm_pkg::op_t o, input logic [47:0] f, input logic [47:0] l);
        op          <= o;
        range_first <= f;
        range_final <= l;
        start       <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_item(o, f, l);
        if (o != umrm_pkg::OP_NONE)
            items_sent++;
        if (!(items_sent >= 140 && items_sent < 220) && $urandom_range(0, 99) < 11)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Sender pause until every expected result is in and the block is idle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input umrm_pkg::reg_idx_t idx, input logic [47:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            umrm_pkg::REG_LIMIT: lim_reg   = 64'(val[4:0]);
            umrm_pkg::REG_KBASE: kbase_reg = 64'(val);
            umrm_pkg::REG_KLEN:  klen_reg  = 64'(val);
            umrm_pkg::REG_BBASE: bbase_reg = 64'(val);
            umrm_pkg::REG_BUSED: bused_reg = 64'(val);
            default: ;
        endcase
    endtask

    function automatic logic [47:0] rand_wide();
        return {16'($urandom_range(0, 65535)), 32'($urandom)};
    endfunction

    // Result monitor
    always @(posedge clk)
    begin
        region_result_t want;
        if (rst_n && result_valid)
        begin
            results_seen++;
            if (status == umrm_pkg::ST_PIECE)
                pieces_seen++;
            if (status == umrm_pkg::ST_DROP_FULL)
                full_drops++;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result, status %0d", status));
            else
            begin
                want = pending_results.pop_front();
                if (status != want.status)
                    report_mismatch($sformatf("status %0d, want %0d", status, want.status));
                if (piece_start != want.start)
                    report_mismatch($sformatf("piece_start %h, want %h", piece_start, want.start));
                if (piece_size != want.size)
                    report_mismatch($sformatf("piece_size %h, want %h", piece_size, want.size));
                if (last != want.last)
                    report_mismatch($sformatf("last %0d, want %0d", last, want.last));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[usable_memory_region_map_unit] ERROR");
            $finish;
        end
    end

    // Directed items: extremes, each op, floor raise, empty, merge, shifted insert
    stim_row_t directed[] = '{
        '{umrm_pkg::OP_SCAN,  48'h0,    48'h0,     1'b0, umrm_pkg::ST_SCAN_END},
        '{umrm_pkg::OP_CLEAR, 48'h0,    48'h0,     1'b1, umrm_pkg::ST_CLEARED},
        '{umrm_pkg::OP_ADD,   48'h0,    48'h0fff,  1'b1, umrm_pkg::ST_DROP_EMPTY},
        '{umrm_pkg::OP_ADD,   48'h0,    48'h1fff,  1'b1, umrm_pkg::ST_INSERTED},
        '{umrm_pkg::OP_ADD,   48'h2000, 48'h2fff,  1'b1, umrm_pkg::ST_MERGED},
        '{umrm_pkg::OP_ADD,   48'h10000, 48'h1ffff, 1'b1, umrm_pkg::ST_INSERTED},
        '{umrm_pkg::OP_ADD,   48'h5000, 48'h5fff,  1'b0, umrm_pkg::ST_INSERTED},
        '{umrm_pkg::OP_ADD,   48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 1'b1,
          umrm_pkg::ST_INSERTED},
        '{umrm_pkg::OP_ADD,   48'hffff_ffff_ffff, 48'h0, 1'b1, umrm_pkg::ST_DROP_EMPTY},
        '{umrm_pkg::OP_ADD,   48'h20000, 48'h3ffff, 1'b0, umrm_pkg::ST_MERGED},
        '{umrm_pkg::OP_ADD,   48'h6000, 48'h7fff,  1'b0, umrm_pkg::ST_MERGED},
        '{umrm_pkg::OP_NONE,  48'haaaa_aaaa_aaaa, 48'h5555_5555_5555, 1'b0,
          umrm_pkg::ST_CLEARED},
        '{umrm_pkg::OP_SCAN,  48'h0,    48'h0,     1'b0, umrm_pkg::ST_SCAN_END},
        '{umrm_pkg::OP_ADD,   48'h5555_5555_5555, 48'haaaa_aaaa_aaaa, 1'b0,
          umrm_pkg::ST_INSERTED},
        '{umrm_pkg::OP_ADD,   48'h2,    48'h1,     1'b1, umrm_pkg::ST_DROP_EMPTY},
        '{umrm_pkg::OP_SCAN,  48'h0,    48'h0,     1'b0, umrm_pkg::ST_SCAN_END},
        '{umrm_pkg::OP_CLEAR, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 1'b1,
          umrm_pkg::ST_CLEARED},
        '{umrm_pkg::OP_SCAN,  48'h0,    48'h0,     1'b0, umrm_pkg::ST_SCAN_END}
    };

    // Stimulus
    initial
    begin
        logic [47:0] cursor, f, l, span;
        int          phase, k, nadd, kind;
        rst_n = 1'b0;
        start = 1'b0;
        op = umrm_pkg::OP_CLEAR;
        range_first = '0;
        range_final = '0;
        cfg_we = 1'b0;
        cfg_index = umrm_pkg::REG_LIMIT;
        cfg_data = '0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        pieces_seen = 0;
        full_drops = 0;
        cycles = 0;
        tbl_count = 0;
        lim_reg = 16;
        kbase_reg = 0;
        klen_reg = 0;
        bbase_reg = 0;
        bused_reg = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[r])
        begin
            issue(directed[r].op, directed[r].first, directed[r].final_addr);
            if (directed[r].typed && last_predicted != directed[r].want)
                report_mismatch($sformatf("directed row %0d status %0d", r, last_predicted));
        end

        // Random phases, each under its own register setting
        for (phase = 0; phase < PHASES; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    write_reg(umrm_pkg::REG_LIMIT, 48'd0);
                    write_reg(umrm_pkg::REG_KBASE, 48'h0);
                    write_reg(umrm_pkg::REG_KLEN, 48'h0);
                    write_reg(umrm_pkg::REG_BBASE, 48'h0);
                    write_reg(umrm_pkg::REG_BUSED, 48'h0);
                end
                1:
                begin
                    write_reg(umrm_pkg::REG_LIMIT, 48'hffff_ffff_ffff);
                    write_reg(umrm_pkg::REG_KBASE, 48'hffff_ffff_ffff);
                    write_reg(umrm_pkg::REG_KLEN, 48'hffff_ffff_ffff);
                    write_reg(umrm_pkg::REG_BBASE, 48'hffff_ffff_ffff);
                    write_reg(umrm_pkg::REG_BUSED, 48'hffff_ffff_ffff);
                end
                2:
                begin
                    write_reg(umrm_pkg::REG_LIMIT, 48'd16);
                    write_reg(umrm_pkg::REG_KBASE, 48'h1000);
                    write_reg(umrm_pkg::REG_KLEN, 48'hffff_ffff_ffff);
                    write_reg(umrm_pkg::REG_BBASE, 48'h0);
                    write_reg(umrm_pkg::REG_BUSED, 48'h0);
                end
                default:
                begin
                    write_reg(umrm_pkg::REG_LIMIT, 48'($urandom_range(1, 20)));
                    write_reg(umrm_pkg::REG_KBASE, 48'($urandom_range(0, 16)) * 48'h4000
                                                   + 48'($urandom_range(0, 3)));
                    write_reg(umrm_pkg::REG_KLEN, ($urandom_range(0, 4) == 0) ? 48'h0 :
                                                  48'($urandom_range(1, 48'h6000)));
                    write_reg(umrm_pkg::REG_BBASE, 48'($urandom_range(0, 16)) * 48'h4000
                                                   + 48'($urandom_range(0, 48'h3fff)));
                    write_reg(umrm_pkg::REG_BUSED, ($urandom_range(0, 4) == 0) ? 48'h0 :
                                                   48'($urandom_range(1, 48'h3000)));
                end
            endcase

            // Well-formed build-up of a table, then scans; some noise mixed in
            for (k = 0; k < 2; k++)
            begin
                issue(umrm_pkg::OP_CLEAR, rand_wide(), rand_wide());
                cursor = ($urandom_range(0, 3) == 0) ? 48'h0 : 48'($urandom_range(0, 48'h3000));
                nadd = $urandom_range(3, 14);
                repeat (nadd)
                begin
                    kind = $urandom_range(0, 99);
                    span = 48'($urandom_range(0, 48'h2fff));
                    if (kind < 15)
                    begin
                        f = cursor + 1;
                        l = f + span;
                    end
                    else if (kind < 22)
                    begin
                        f = rand_wide();
                        l = rand_wide();
                    end
                    else if (kind < 27)
                    begin
                        f = cursor + 48'h100;
                        l = f - 1;
                    end
                    else if (kind < 35 && cursor > 48'h8000)
                    begin
                        f = cursor - 48'($urandom_range(48'h2000, 48'h7000));
                        l = f + 48'($urandom_range(0, 48'h800));
                    end
                    else
                    begin
                        f = cursor + 48'($urandom_range(2, 48'h1800));
                        l = f + span;
                    end
                    if (kind < 15 || kind >= 35)
                        cursor = l;
                    issue(umrm_pkg::OP_ADD, f, l);
                    if ($urandom_range(0, 9) == 0)
                        issue(umrm_pkg::OP_NONE, rand_wide(), rand_wide());
                end
                issue(umrm_pkg::OP_SCAN, rand_wide(), rand_wide());
                if ($urandom_range(0, 1) == 0)
                    issue(umrm_pkg::OP_SCAN, rand_wide(), rand_wide());
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d items over %0d register settings: %0d results, %0d free pieces",
                 items_sent, PHASES, results_seen, pieces_seen);
        $display("table-full drops seen: %0d, mismatches: %0d", full_drops, errors);
        if (errors == 0 && pending_results.size() == 0)
            $display("[usable_memory_region_map_unit] OK");
        else
            $display("[usable_memory_region_map_unit] ERROR");
        $finish;
    end
endmodule

// File: filelist.f
hdl/umrm_pkg.sv
hdl/umrm_cell.sv
hdl/umrm_row.sv
hdl/usable_memory_region_map_unit.sv
dv/tb.sv
